// ----- rtl/graph_bfs_hop_distance_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the BFS hop distance block
// Implication checks used by the RTL module that asserts.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_HOP_DISTANCE_DEFINES_SVH
`define GRAPH_BFS_HOP_DISTANCE_DEFINES_SVH

// Same-cycle implication
`define GBFS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication
`define GBFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- rtl/gbfs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared constants, codes and types of the BFS hop distance block.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  localparam int ROW_CAP          = 32;  // widest adjacency row supported
  localparam int NUM_VERTICES_DEF = 32;
  localparam int VW               = 5;   // vertex and distance field width
  localparam int CW               = 6;   // vertex count width
  localparam int OPW              = 2;
  localparam int STW              = 2;

  localparam logic [OPW-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPW-1:0] OP_ADD    = 2'd1;
  localparam logic [OPW-1:0] OP_SEARCH = 2'd2;

  localparam logic [STW-1:0] ST_OK    = 2'd0;
  localparam logic [STW-1:0] ST_RANGE = 2'd1;
  localparam logic [STW-1:0] ST_DUP   = 2'd2;

  localparam logic [CW-1:0] VERTEX_COUNT_RST = 6'd32;

  typedef struct packed {
    logic clear;
    logic wr_en;
  } adj_cmd_t;

endpackage

// ----- rtl/graph_bfs_hop_distance.sv -----
// Clear and rejected requests: one status result the cycle after acceptance.
// Add edge: one status result after a read-modify-write of each end's row; a duplicate stops at the first.
// Search: one result per vertex in use, the last flagged by last; adjacency rows are read through
// the single adjacency read port, one row per dequeued vertex, one neighbour a cycle.
// busy is high while an add or search holds the state machine; one request at a time.
// Synchronous reset empties the graph, clears the visit marks and sets the count to 32.
`include "graph_bfs_hop_distance_defines.svh"
// ----------------------------------------------------------------------------
// graph_bfs_hop_distance
// Adjacency-bit graph store with breadth-first hop distance search.
// ----------------------------------------------------------------------------
module graph_bfs_hop_distance #(
  parameter int NUM_VERTICES = gbfs_pkg::NUM_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [gbfs_pkg::OPW-1:0] opcode,
  input  logic [gbfs_pkg::VW-1:0]  first_vertex,
  input  logic [gbfs_pkg::VW-1:0]  second_vertex,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [gbfs_pkg::CW-1:0]  cfg_data,
  output logic                     result_valid,
  output logic [gbfs_pkg::VW-1:0]  vertex_index,
  output logic [gbfs_pkg::VW-1:0]  hop_distance,
  output logic                     reachable,
  output logic [gbfs_pkg::STW-1:0] status,
  output logic                     last
);
  import gbfs_pkg::*;

  localparam int ROWS = (NUM_VERTICES < ROW_CAP) ? NUM_VERTICES : ROW_CAP;
  localparam int AW   = $clog2(ROWS);
  localparam int PW   = AW + 1;
  localparam logic [CW-1:0] ROWS_C = CW'(ROWS);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_EDGE_CHK   = 9'b000000010,
    S_EDGE_SET_B = 9'b000000100,
    S_BFS_POP    = 9'b000001000,
    S_BFS_ROW    = 9'b000010000,
    S_BFS_LOAD   = 9'b000100000,
    S_BFS_SCAN   = 9'b001000000,
    S_EMIT       = 9'b010000000,
    S_DRAIN      = 9'b100000000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   vertex_count;
  logic [AW-1:0]   op_a, op_b;
  logic [PW-1:0]   head, tail, level_end;
  logic [VW-1:0]   level;
  logic [ROWS-1:0] nbrs, visit;
  logic [VW-1:0]   emit_v;
  logic            p1_valid, p1_seen, p1_last;
  logic [VW-1:0]   p1_v;

  logic [CW-1:0]   n_use;
  logic [ROWS-1:0] row_mask;
  logic            accept, a_bad, b_bad;
  logic [ROWS-1:0] low_bit;
  logic [AW-1:0]   low_idx;

  adj_cmd_t        adj_cmd;
  logic [AW-1:0]   adj_wr_addr, adj_rd_addr;
  logic [ROWS-1:0] adj_wr_data, adj_row;
  logic            q_we;
  logic [AW-1:0]   q_wr_addr, q_wr_data, q_rd_data;
  logic            d_we;
  logic [AW-1:0]   d_wr_addr;
  logic [VW-1:0]   d_wr_data, d_rd_data;
  logic            st_emit;
  logic [STW-1:0]  st_code;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign n_use     = (vertex_count > ROWS_C) ? ROWS_C : vertex_count;
  assign a_bad     = ({1'b0, first_vertex} >= n_use);
  assign b_bad     = ({1'b0, second_vertex} >= n_use);

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      row_mask[i] = (CW'(i) < n_use);
    end
  end

  // lowest pending neighbour
  assign low_bit = nbrs & (~nbrs + ROWS'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < ROWS; i++) begin
      low_idx = low_idx | (low_bit[i] ? AW'(i) : AW'(0));
    end
  end

  always_comb begin
    state_next  = state;
    adj_cmd     = '0;
    adj_wr_addr = op_a;
    adj_wr_data = adj_row | (ROWS'(1) << op_b);
    adj_rd_addr = op_b;
    q_we        = 1'b0;
    q_wr_addr   = tail[AW-1:0];
    q_wr_data   = low_idx;
    d_we        = 1'b0;
    d_wr_addr   = low_idx;
    d_wr_data   = level + VW'(1);
    st_emit     = 1'b0;
    st_code     = ST_OK;
    unique case (state)
      S_IDLE: begin
        adj_rd_addr = first_vertex[AW-1:0];
        if (accept) begin
          unique case (opcode)
            OP_CLEAR: begin
              adj_cmd.clear = 1'b1;
              st_emit       = 1'b1;
            end
            OP_ADD: begin
              if (a_bad || b_bad) begin
                st_emit = 1'b1;
                st_code = ST_RANGE;
              end else begin
                state_next = S_EDGE_CHK;
              end
            end
            OP_SEARCH: begin
              if (a_bad) begin
                st_emit = 1'b1;
                st_code = ST_RANGE;
              end else begin
                q_we       = 1'b1;
                q_wr_addr  = '0;
                q_wr_data  = first_vertex[AW-1:0];
                d_we       = 1'b1;
                d_wr_addr  = first_vertex[AW-1:0];
                d_wr_data  = '0;
                state_next = S_BFS_POP;
              end
            end
            default: ;
          endcase
        end
      end
      S_EDGE_CHK: begin
        // row of the first end is back from the store
        if (adj_row[op_b]) begin
          st_emit    = 1'b1;
          st_code    = ST_DUP;
          state_next = S_IDLE;
        end else begin
          adj_cmd.wr_en = 1'b1;
          state_next    = S_EDGE_SET_B;
        end
      end
      S_EDGE_SET_B: begin
        adj_cmd.wr_en = 1'b1;
        adj_wr_addr   = op_b;
        adj_wr_data   = adj_row | (ROWS'(1) << op_a);
        st_emit       = 1'b1;
        state_next    = S_IDLE;
      end
      S_BFS_POP: begin
        state_next = (head == tail) ? S_EMIT : S_BFS_ROW;
      end
      S_BFS_ROW: begin
        adj_rd_addr = q_rd_data;
        state_next  = S_BFS_LOAD;
      end
      S_BFS_LOAD: begin
        state_next = S_BFS_SCAN;
      end
      S_BFS_SCAN: begin
        if (nbrs == '0) begin
          state_next = S_BFS_POP;
        end else begin
          q_we = 1'b1;
          d_we = 1'b1;
        end
      end
      S_EMIT: begin
        if (({1'b0, emit_v} + CW'(1)) == n_use) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VERTEX_COUNT_RST;
      visit        <= '0;
      head         <= '0;
      tail         <= '0;
      p1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (state == S_IDLE && accept && opcode == OP_SEARCH && !a_bad) begin
        visit <= ROWS'(1) << first_vertex[AW-1:0];
        head  <= '0;
        tail  <= PW'(1);
      end
      if (state == S_BFS_POP && head != tail) begin
        head <= head + PW'(1);
      end
      if (state == S_BFS_SCAN && nbrs != '0) begin
        visit <= visit | low_bit;
        tail  <= tail + PW'(1);
      end
      p1_valid     <= (state == S_EMIT);
      result_valid <= p1_valid || st_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      op_a      <= first_vertex[AW-1:0];
      op_b      <= second_vertex[AW-1:0];
      level     <= '0;
      level_end <= PW'(1);
    end
    // entering a new level of the queue
    if (state == S_BFS_POP && head != tail && head == level_end) begin
      level     <= level + VW'(1);
      level_end <= tail;
    end
    if (state == S_BFS_LOAD) begin
      nbrs <= adj_row & row_mask & ~visit;
    end
    if (state == S_BFS_SCAN) begin
      nbrs <= nbrs & ~low_bit;
    end
    if (state == S_BFS_POP) begin
      emit_v <= '0;
    end
    if (state == S_EMIT) begin
      emit_v  <= emit_v + VW'(1);
      p1_v    <= emit_v;
      p1_seen <= visit[emit_v[AW-1:0]];
      p1_last <= (({1'b0, emit_v} + CW'(1)) == n_use);
    end
    if (p1_valid) begin
      vertex_index <= p1_v;
      hop_distance <= p1_seen ? d_rd_data : '0;
      reachable    <= p1_seen;
      status       <= ST_OK;
      last         <= p1_last;
    end else if (st_emit) begin
      vertex_index <= '0;
      hop_distance <= '0;
      reachable    <= 1'b0;
      status       <= st_code;
      last         <= 1'b1;
    end
  end

  gbfs_adj_mem #(
    .ROWS (ROWS),
    .AW   (AW)
  ) u_adj_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd     (adj_cmd),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .rd_addr (adj_rd_addr),
    .rd_row  (adj_row)
  );

  gbfs_ram #(
    .W  (AW),
    .D  (ROWS),
    .AW (AW)
  ) u_queue (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_wr_addr),
    .wr_data (q_wr_data),
    .rd_addr (head[AW-1:0]),
    .rd_data (q_rd_data)
  );

  gbfs_ram #(
    .W  (VW),
    .D  (ROWS),
    .AW (AW)
  ) u_dist (
    .clk     (clk),
    .wr_en   (d_we),
    .wr_addr (d_wr_addr),
    .wr_data (d_wr_data),
    .rd_addr (emit_v[AW-1:0]),
    .rd_data (d_rd_data)
  );

  `GBFS_ASSERT_IMPLY(a_queue_bound, clk, rst, 1'b1, (head <= tail) && (tail <= PW'(ROWS)))
  `GBFS_ASSERT_IMPLY(a_scan_unvisited, clk, rst, state == S_BFS_SCAN, (low_bit & visit) == '0)
  `GBFS_ASSERT_IMPLY(a_status_single, clk, rst, result_valid && status != ST_OK, last && !reachable)
  `GBFS_ASSERT_NEXT(a_edge_done, clk, rst, state == S_EDGE_SET_B, result_valid && status == ST_OK)

endmodule

// ----- rtl/gbfs_ram.sv -----
// ----------------------------------------------------------------------------
// gbfs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbfs_ram #(
  parameter int W  = gbfs_pkg::VW,
  parameter int D  = gbfs_pkg::ROW_CAP,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);
  import gbfs_pkg::*;

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/gbfs_adj_mem.sv -----
// ----------------------------------------------------------------------------
// gbfs_adj_mem
// Adjacency row store with per-row valid bits; an invalid row reads as empty.
// ----------------------------------------------------------------------------
module gbfs_adj_mem #(
  parameter int ROWS = gbfs_pkg::ROW_CAP,
  parameter int AW   = $clog2(ROWS)
) (
  input  logic               clk,
  input  logic               rst,
  input  gbfs_pkg::adj_cmd_t cmd,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ROWS-1:0]    wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [ROWS-1:0]    rd_row
);
  import gbfs_pkg::*;

  logic [ROWS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [ROWS-1:0] rd_data;
  logic            rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // clear drops every valid bit at once
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row_valid <= '0;
    end else if (cmd.wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= row_valid[rd_addr];
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule
